FILE: rtl/box_blur_3x3_assert.svh
// Assertion macros shared by the box blur checker.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef BOX_BLUR_3X3_ASSERT_SVH
`define BOX_BLUR_3X3_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define BB3_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box blur check failed (same cycle)");

// Consequent checked in the cycle after the antecedent
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box blur check failed (next cycle)");

`endif

FILE: rtl/bb3_pkg.sv
// Shared constants, types and tables for the 3x3 box blur.
// No dependencies; imported by bb3_ctrl, bb3_datapath, box_blur_3x3 and the testbench.
`timescale 1ns / 1ps

package bb3_pkg;

   // frame limits and geometry register format
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int DIM_W      = 11;
   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   // written-minus-emitted count, peaks at width plus two
   localparam int LAG_W = $clog2(MAX_WIDTH + 3);

   // three line stores in rotation by row mod 3
   localparam int NUM_BANKS = 3;
   localparam int BANK_W    = 2;

   // pixel channels
   localparam int NUM_CH   = 3;
   localparam int CH_W     = 8;
   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   // mean arithmetic: sum of up to nine channels, count 1..9
   localparam int SUM_W       = $clog2(9 * 255 + 1);
   localparam int NUM_W       = 4;
   localparam int X_W         = SUM_W + 1;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 20;
   localparam int PROD_W      = X_W + RECIP_W;

   // input operation code
   localparam logic OP_PIXEL = 1'b0;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [NUM_CH-1:0][CH_W-1:0] bb3_pixel_type;

   typedef enum logic [1:0] {
      STEP_LEFT,
      STEP_CENTRE,
      STEP_RIGHT
   } bb3_step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_MUL,
      ST_OUT
   } bb3_state_type;

   typedef struct packed {
      logic         accept;
      logic         rd_en;
      bb3_step_type rd_step;
      logic         mul_en;
      logic         out_load;
   } bb3_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } bb3_status_type;

   // ceil(2^20 / (2n)); (2*sum+n) * recip >> 20 gives the rounded mean exactly
   function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd1:    m = 20'd524288;
         4'd2:    m = 20'd262144;
         4'd3:    m = 20'd174763;
         4'd4:    m = 20'd131072;
         4'd5:    m = 20'd104858;
         4'd6:    m = 20'd87382;
         4'd7:    m = 20'd74899;
         4'd8:    m = 20'd65536;
         4'd9:    m = 20'd58255;
         default: m = 20'd524288;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/bb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the box blur line stores.
`timescale 1ns / 1ps

module bb3_ram #(
   parameter int  WIDTH  = 24,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bb3_ctrl.sv
// Sequencer for the box blur: accepts words, runs the three column reads,
// the multiply and the output load. Depends on bb3_pkg.
`timescale 1ns / 1ps

module bb3_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bb3_pkg::bb3_status_type status,
   output bb3_pkg::bb3_cmd_type    cmd
);

   import bb3_pkg::*;

   bb3_state_type state_ff, state_in;
   bb3_step_type  step_ff, step_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_LEFT;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.emit) begin
               state_in = ST_READ;
               step_in  = STEP_LEFT;
            end
         end
         ST_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_step = step_ff;
            unique case (step_ff)
               STEP_LEFT:   step_in = STEP_CENTRE;
               STEP_CENTRE: step_in = STEP_RIGHT;
               default: begin
                  step_in  = STEP_LEFT;
                  state_in = ST_DRAIN;
               end
            endcase
         end
         // last column's read data lands in the accumulator
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_OUT;
         end
         // hold until the output register is free
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/bb3_datapath.sv
// Box blur datapath: geometry registers, frame counters, line stores,
// neighbourhood accumulator, reciprocal divide and output register.
// Depends on bb3_pkg and bb3_ram.
`timescale 1ns / 1ps

module bb3_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  bb3_pkg::bb3_cmd_type             cmd,
   output bb3_pkg::bb3_status_type          status,
   input  logic                             req_operation,
   input  logic [7:0]                       req_pixel_red,
   input  logic [7:0]                       req_pixel_green,
   input  logic [7:0]                       req_pixel_blue,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bb3_pkg::DIM_W-1:0]        csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_blur_red,
   output logic [7:0]                       rsp_blur_green,
   output logic [7:0]                       rsp_blur_blue,
   output logic                             rsp_frame_end
);

   import bb3_pkg::*;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int max_val);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_val) begin
         r = DIM_W'(max_val);
      end
      return r;
   endfunction

   function automatic logic [BANK_W-1:0] bank_next(input logic [BANK_W-1:0] b);
      return (b == BANK_W'(NUM_BANKS - 1)) ? '0 : BANK_W'(b + BANK_W'(1));
   endfunction

   function automatic logic [BANK_W-1:0] bank_prev(input logic [BANK_W-1:0] b);
      return (b == '0) ? BANK_W'(NUM_BANKS - 1) : BANK_W'(b - BANK_W'(1));
   endfunction

   logic [DIM_W-1:0]  image_width_ff, image_width_in;
   logic [DIM_W-1:0]  image_height_ff, image_height_in;
   logic [DIM_W-1:0]  act_w_ff, act_w_in, act_h_ff, act_h_in;
   logic [DIM_W-1:0]  cfg_w, cfg_h, eff_w, eff_h;
   logic              frame_open_ff, frame_open_in;
   logic              input_complete_ff, input_complete_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in, rd_addr;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [BANK_W-1:0] in_bank_ff, in_bank_in, out_bank_ff, out_bank_in;
   logic [BANK_W-1:0] up_bank, dn_bank;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic              is_pixel, do_write, wr_en;
   logic              col_last, row_last, out_col_last, out_row_last;
   bb3_pixel_type     wr_pix;
   bb3_pixel_type     rd_pix [NUM_BANKS];
   logic              rd_pending_ff;
   bb3_step_type      rd_step_ff;
   logic              above_ok, below_ok, col_ok;
   logic [NUM_W-1:0]  rows_ok;
   logic [SUM_W-1:0]  sum_ff [NUM_CH];
   logic [SUM_W-1:0]  sum_in [NUM_CH];
   logic [NUM_W-1:0]  n_ff, n_in;
   logic [X_W-1:0]    x_val [NUM_CH];
   logic [PROD_W-1:0] prod_ff [NUM_CH];
   bb3_pixel_type     rsp_pix_ff;
   logic              rsp_valid_ff, rsp_valid_in, rsp_frame_end_ff;

   assign csr_ready = 1'b1;

   // item decode and frame bookkeeping
   always_comb begin
      image_width_in    = image_width_ff;
      image_height_in   = image_height_ff;
      act_w_in          = act_w_ff;
      act_h_in          = act_h_ff;
      frame_open_in     = frame_open_ff;
      input_complete_in = input_complete_ff;
      in_col_in         = in_col_ff;
      in_row_in         = in_row_ff;
      in_bank_in        = in_bank_ff;
      out_col_in        = out_col_ff;
      out_row_in        = out_row_ff;
      out_bank_in       = out_bank_ff;
      lag_in            = lag_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_data;
            CSR_IMAGE_HEIGHT: image_height_in = csr_data;
            default: ;
         endcase
      end

      // geometry: latched values inside a frame, register values at its start
      cfg_w = clamp_dim(image_width_ff, MAX_WIDTH);
      cfg_h = clamp_dim(image_height_ff, MAX_HEIGHT);
      eff_w = frame_open_ff ? act_w_ff : cfg_w;
      eff_h = frame_open_ff ? act_h_ff : cfg_h;

      is_pixel = (req_operation == OP_PIXEL);
      do_write = is_pixel && !input_complete_ff;
      col_last = (int'(in_col_ff) + 1) >= int'(eff_w);
      row_last = (int'(in_row_ff) + 1) >= int'(eff_h);
      wr_en    = cmd.accept && do_write;

      // a result is due once its below-right pixel is in or input is done
      if (do_write) begin
         status.emit = (col_last && row_last) || (int'(lag_ff) >= (int'(eff_w) + 1));
      end else begin
         status.emit = input_complete_ff;
      end
      status.out_free = !rsp_valid_ff || !rsp_stall;

      out_col_last = (int'(out_col_ff) + 1) >= int'(act_w_ff);
      out_row_last = (int'(out_row_ff) + 1) >= int'(act_h_ff);

      if (cmd.accept) begin
         if (!frame_open_ff && is_pixel) begin
            frame_open_in = 1'b1;
            act_w_in      = cfg_w;
            act_h_in      = cfg_h;
         end
         if (do_write) begin
            lag_in = LAG_W'(lag_ff + LAG_W'(1));
            if (col_last) begin
               in_col_in  = '0;
               in_row_in  = ROW_W'(in_row_ff + ROW_W'(1));
               in_bank_in = bank_next(in_bank_ff);
               if (row_last) begin
                  input_complete_in = 1'b1;
               end
            end else begin
               in_col_in = COL_W'(in_col_ff + COL_W'(1));
            end
         end
      end

      if (cmd.out_load) begin
         lag_in = LAG_W'(lag_ff - LAG_W'(1));
         if (out_col_last) begin
            out_col_in = '0;
            if (out_row_last) begin
               // frame done: back to the start state
               out_row_in        = '0;
               out_bank_in       = '0;
               in_col_in         = '0;
               in_row_in         = '0;
               in_bank_in        = '0;
               lag_in            = '0;
               input_complete_in = 1'b0;
               frame_open_in     = 1'b0;
            end else begin
               out_row_in  = ROW_W'(out_row_ff + ROW_W'(1));
               out_bank_in = bank_next(out_bank_ff);
            end
         end else begin
            out_col_in = COL_W'(out_col_ff + COL_W'(1));
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= DIM_RESET;
         image_height_ff   <= DIM_RESET;
         act_w_ff          <= DIM_RESET;
         act_h_ff          <= DIM_RESET;
         frame_open_ff     <= 1'b0;
         input_complete_ff <= 1'b0;
         in_col_ff         <= '0;
         in_row_ff         <= '0;
         in_bank_ff        <= '0;
         out_col_ff        <= '0;
         out_row_ff        <= '0;
         out_bank_ff       <= '0;
         lag_ff            <= '0;
         rd_pending_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         image_width_ff    <= image_width_in;
         image_height_ff   <= image_height_in;
         act_w_ff          <= act_w_in;
         act_h_ff          <= act_h_in;
         frame_open_ff     <= frame_open_in;
         input_complete_ff <= input_complete_in;
         in_col_ff         <= in_col_in;
         in_row_ff         <= in_row_in;
         in_bank_ff        <= in_bank_in;
         out_col_ff        <= out_col_in;
         out_row_ff        <= out_row_in;
         out_bank_ff       <= out_bank_in;
         lag_ff            <= lag_in;
         rd_pending_ff     <= cmd.rd_en;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // line stores, one per row mod 3
   assign wr_pix[CH_RED]   = req_pixel_red;
   assign wr_pix[CH_GREEN] = req_pixel_green;
   assign wr_pix[CH_BLUE]  = req_pixel_blue;

   always_comb begin
      case (cmd.rd_step)
         STEP_LEFT:   rd_addr = COL_W'(out_col_ff - COL_W'(1));
         STEP_CENTRE: rd_addr = out_col_ff;
         STEP_RIGHT:  rd_addr = COL_W'(out_col_ff + COL_W'(1));
         default:     rd_addr = out_col_ff;
      endcase
   end

   for (genvar gi = 0; gi < NUM_BANKS; gi++) begin : g_bank
      bb3_ram #(
         .WIDTH($bits(bb3_pixel_type)),
         .DEPTH(MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (wr_en && (in_bank_ff == BANK_W'(gi))),
         .wr_addr (in_col_ff),
         .wr_data (wr_pix),
         .rd_en   (cmd.rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_pix[gi])
      );
   end

   // column accumulate: above, centre and below rows of one column
   always_comb begin
      up_bank  = bank_prev(out_bank_ff);
      dn_bank  = bank_next(out_bank_ff);
      above_ok = (out_row_ff != '0);
      below_ok = (int'(out_row_ff) + 1) < int'(act_h_ff);
      rows_ok  = NUM_W'(1) + NUM_W'(above_ok) + NUM_W'(below_ok);
      case (rd_step_ff)
         STEP_LEFT:   col_ok = (out_col_ff != '0);
         STEP_CENTRE: col_ok = 1'b1;
         STEP_RIGHT:  col_ok = (int'(out_col_ff) + 1) < int'(act_w_ff);
         default:     col_ok = 1'b0;
      endcase
      n_in = n_ff;
      if (rd_pending_ff && col_ok) begin
         n_in = NUM_W'(n_ff + rows_ok);
      end
      for (int c = 0; c < NUM_CH; c++) begin
         sum_in[c] = sum_ff[c];
         if (rd_pending_ff && col_ok) begin
            sum_in[c] = SUM_W'(sum_ff[c] + SUM_W'(rd_pix[out_bank_ff][c])
                        + (above_ok ? SUM_W'(rd_pix[up_bank][c]) : '0)
                        + (below_ok ? SUM_W'(rd_pix[dn_bank][c]) : '0));
         end
         x_val[c] = X_W'({sum_ff[c], 1'b0}) + X_W'(n_ff);
      end
   end

   // output handshake register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_step_ff <= cmd.rd_step;
      if (cmd.accept) begin
         n_ff <= '0;
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         n_ff <= n_in;
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
      // rounded mean by reciprocal multiply
      if (cmd.mul_en) begin
         for (int c = 0; c < NUM_CH; c++) begin
            prod_ff[c] <= PROD_W'(x_val[c]) * PROD_W'(recip(n_ff));
         end
      end
      if (cmd.out_load) begin
         for (int c = 0; c < NUM_CH; c++) begin
            rsp_pix_ff[c] <= prod_ff[c][RECIP_SHIFT +: CH_W];
         end
         rsp_frame_end_ff <= out_col_last && out_row_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blur_red   = rsp_pix_ff[CH_RED];
   assign rsp_blur_green = rsp_pix_ff[CH_GREEN];
   assign rsp_blur_blue  = rsp_pix_ff[CH_BLUE];
   assign rsp_frame_end  = rsp_frame_end_ff;

endmodule

FILE: rtl/box_blur_3x3.sv
// 3x3 box blur, edge-normalised mean of each RGB pixel's neighbourhood.
// After a word with a result, req_stall is high through three column reads of
// the line-store RAMs, accumulate, multiply and the load onto rsp, which waits
// for a free output register; words with no result are accepted back to back.
// Reset: synchronous, active high; clears counters, flags and geometry to 1024.
// Line stores are not cleared; no clearing pass is run after reset.
`timescale 1ns / 1ps

module box_blur_3x3 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [7:0]                    req_pixel_red,
   input  logic [7:0]                    req_pixel_green,
   input  logic [7:0]                    req_pixel_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_blur_red,
   output logic [7:0]                    rsp_blur_green,
   output logic [7:0]                    rsp_blur_blue,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bb3_pkg::DIM_W-1:0]     csr_data
);

   import bb3_pkg::*;

   bb3_cmd_type    cmd;
   bb3_status_type status;

   // sequencer
   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   bb3_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blur_red    (rsp_blur_red),
      .rsp_blur_green  (rsp_blur_green),
      .rsp_blur_blue   (rsp_blur_blue),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

FILE: rtl/bb3_checker.sv
// Port-level checks for the box blur, attached to the top level by bind.
// Depends on box_blur_3x3_assert.svh and box_blur_3x3.
`timescale 1ns / 1ps
`include "box_blur_3x3_assert.svh"

module bb3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_blur_red,
   input logic [7:0] rsp_blur_green,
   input logic [7:0] rsp_blur_blue,
   input logic       rsp_frame_end
);

   // input side open straight after reset
   `BB3_ASSERT_SAME(a_idle_after_reset, $past(reset), !req_stall)

   // a new result only appears after a busy cycle on the input side
   `BB3_ASSERT_SAME(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall))

   // a stalled result word holds
   `BB3_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_blur_red) && $stable(rsp_blur_green) && $stable(rsp_blur_blue) && $stable(rsp_frame_end))

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_blur_red   (rsp_blur_red),
   .rsp_blur_green (rsp_blur_green),
   .rsp_blur_blue  (rsp_blur_blue),
   .rsp_frame_end  (rsp_frame_end)
);

FILE: tb/box_blur_3x3_checker.sv
// Scoreboard for the 3x3 box blur: watches the csr, req and rsp channels,
// predicts every blurred word and compares it field by field.
// Depends on bb3_pkg for geometry limits, channel order and register indexes.
`timescale 1ns / 1ps

module box_blur_3x3_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_operation,
   input  logic [7:0]                    req_pixel_red,
   input  logic [7:0]                    req_pixel_green,
   input  logic [7:0]                    req_pixel_blue,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [7:0]                    rsp_blur_red,
   input  logic [7:0]                    rsp_blur_green,
   input  logic [7:0]                    rsp_blur_blue,
   input  logic                          rsp_frame_end,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bb3_pkg::DIM_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending_results
);

   import bb3_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blurred_word_type;

   // shadow of the frame: three rows in rotation, geometry and raster counters
   bb3_pixel_type    row_bank [NUM_BANKS][MAX_WIDTH];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   int unsigned      frame_w, frame_h;
   int unsigned      in_row, in_col, out_row, out_col;
   logic             input_done;
   logic             frame_open;
   blurred_word_type blur_q [$];

   // zero reads as one, anything past the limit as the limit
   function automatic int unsigned usable_dim(logic [DIM_W-1:0] code, int unsigned limit);
      if (code == '0)
         return 1;
      if (code > limit)
         return limit;
      return code;
   endfunction

   task automatic flag_fault(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   // mean of the in-frame neighbours of the next output pixel, then advance
   task automatic queue_blur();
      int               rr, cc;
      int unsigned      sum_r, sum_g, sum_b, n;
      bb3_pixel_type    px;
      blurred_word_type word;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = int'(out_row) + dr;
            cc = int'(out_col) + dc;
            if (rr >= 0 && rr < int'(frame_h) && cc >= 0 && cc < int'(frame_w)) begin
               px = row_bank[rr % NUM_BANKS][cc];
               sum_r += px[CH_RED];
               sum_g += px[CH_GREEN];
               sum_b += px[CH_BLUE];
               n++;
            end
         end
      end
      word.red       = 8'((2 * sum_r + n) / (2 * n));
      word.green     = 8'((2 * sum_g + n) / (2 * n));
      word.blue      = 8'((2 * sum_b + n) / (2 * n));
      word.frame_end = 1'b0;
      out_col++;
      if (out_col >= frame_w) begin
         out_col = 0;
         out_row++;
         if (out_row >= frame_h) begin
            word.frame_end = 1'b1;
            in_row = 0;
            in_col = 0;
            out_row = 0;
            input_done = 1'b0;
            frame_open = 1'b0;
         end
      end
      blur_q.push_back(word);
   endtask

   // one accepted req word: store the pixel, emit when the window is complete
   task automatic absorb_word(logic op, bb3_pixel_type px);
      int unsigned wr_pos, rd_pos;
      logic        due;
      if (!frame_open) begin
         // flush with no frame open is dropped; a pixel latches the geometry
         if (op != OP_PIXEL)
            return;
         frame_w = usable_dim(width_reg, MAX_WIDTH);
         frame_h = usable_dim(height_reg, MAX_HEIGHT);
         frame_open = 1'b1;
      end
      if (op == OP_PIXEL && !input_done) begin
         wr_pos = in_row * frame_w + in_col;
         rd_pos = out_row * frame_w + out_col;
         row_bank[in_row % NUM_BANKS][in_col] = px;
         in_col++;
         if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
            if (in_row >= frame_h)
               input_done = 1'b1;
         end
         due = input_done || (wr_pos >= rd_pos + frame_w + 1);
      end else begin
         // flush, or a pixel past the end acting as one; early flush dropped
         if (!input_done)
            return;
         due = 1'b1;
      end
      if (due)
         queue_blur();
   endtask

   task automatic check_word(blurred_word_type got);
      blurred_word_type want;
      if (blur_q.size() == 0) begin
         flag_fault($sformatf("unexpected blur word r=%0d g=%0d b=%0d end=%0b",
                              got.red, got.green, got.blue, got.frame_end));
         return;
      end
      want = blur_q.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.frame_end !== want.frame_end)
         flag_fault($sformatf({"blur mismatch: expected r=%0d g=%0d b=%0d end=%0b, ",
                               "got r=%0d g=%0d b=%0d end=%0b"},
                              want.red, want.green, want.blue, want.frame_end,
                              got.red, got.green, got.blue, got.frame_end));
   endtask

   // outputs are sampled before this edge updates them
   always @(posedge clock) begin
      if (reset) begin
         width_reg = DIM_RESET;
         height_reg = DIM_RESET;
         frame_w = MAX_WIDTH;
         frame_h = MAX_HEIGHT;
         in_row = 0;
         in_col = 0;
         out_row = 0;
         out_col = 0;
         input_done = 1'b0;
         frame_open = 1'b0;
         blur_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               width_reg = csr_data;
            else if (csr_index == CSR_IMAGE_HEIGHT)
               height_reg = csr_data;
         end
         if (req_valid && !req_stall)
            absorb_word(req_operation, {req_pixel_red, req_pixel_green, req_pixel_blue});
         if (rsp_valid && !rsp_stall)
            check_word({rsp_blur_red, rsp_blur_green, rsp_blur_blue, rsp_frame_end});
      end
      pending_results = blur_q.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the box blur testbench: clock, reset, stimulus and verdict.
// Instantiates box_blur_3x3 and box_blur_3x3_checker; uses bb3_pkg.
`timescale 1ns / 1ps

module tb;
   import bb3_pkg::*;

   localparam logic OP_FLUSH        = ~OP_PIXEL;
   localparam int   SETTLE_CYCLES   = 16;
   localparam int   CYCLE_LIMIT     = 1_000_000;
   localparam int   WORDS_PER_PHASE = 40;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_operation   = OP_PIXEL;
   logic [7:0]           req_pixel_red   = '0;
   logic [7:0]           req_pixel_green = '0;
   logic [7:0]           req_pixel_blue  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [7:0]           rsp_blur_red;
   logic [7:0]           rsp_blur_green;
   logic [7:0]           rsp_blur_blue;
   logic                 rsp_frame_end;
   logic                 csr_valid       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [DIM_W-1:0]     csr_data        = '0;
   logic                 csr_ready;
   int                   fail_count;
   int                   pending_results;

   int          send_gap_pct   = 0;
   int          recv_stall_pct = 0;
   int          words_sent     = 0;
   int unsigned width_code     = 1024;
   int unsigned height_code    = 1024;

   box_blur_3x3 dut (.*);

   box_blur_3x3_checker checker_i (.*);

   always #2 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [7:0] random_level();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic bb3_pixel_type random_pixel();
      return {random_level(), random_level(), random_level()};
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_word(logic op, bb3_pixel_type px);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_pixel_red   <= px[CH_RED];
      req_pixel_green <= px[CH_GREEN];
      req_pixel_blue  <= px[CH_BLUE];
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // stop sending, let every expected word out, then allow for latency
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes follow without a gap
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[DIM_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_geometry(logic do_w, int unsigned w_code, logic do_h, int unsigned h_code);
      settle();
      if (do_w) begin
         write_reg(CSR_IMAGE_WIDTH, w_code);
         width_code = w_code;
      end
      if (do_h) begin
         write_reg(CSR_IMAGE_HEIGHT, h_code);
         height_code = h_code;
      end
      csr_valid <= 1'b0;
   endtask

   // one well-formed frame plus a little noise; w and h are the sizes in use
   task automatic send_frame(int unsigned w, int unsigned h);
      int unsigned drain;
      for (int unsigned k = 0; k < w * h; k++) begin
         // stray flush while pixels are still due is dropped
         if ($urandom_range(19) == 0)
            push_word(OP_FLUSH, random_pixel());
         push_word(OP_PIXEL, random_pixel());
      end
      drain = (w * h - 1 < w + 1) ? w * h - 1 : w + 1;
      // a pixel in the drain phase stands in for a flush
      for (int unsigned k = 0; k < drain; k++)
         push_word(($urandom_range(99) < 15) ? OP_PIXEL : OP_FLUSH, random_pixel());
      if ($urandom_range(9) == 0)
         push_word(OP_FLUSH, random_pixel());
   endtask

   task automatic random_frame();
      logic        do_w, do_h;
      int unsigned w_code, h_code;
      do_w   = ($urandom_range(9) < 7);
      do_h   = ($urandom_range(9) < 7);
      w_code = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      h_code = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      set_geometry(do_w, w_code, do_h, h_code);
      send_frame((width_code == 0) ? 1 : width_code, (height_code == 0) ? 1 : height_code);
   endtask

   initial begin : stimulus
      int phase_start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct   = 22;
      recv_stall_pct = 55;
      @(negedge clock);

      // flush with no frame open
      push_word(OP_FLUSH, '1);

      // 2x2 frame: extreme levels, early flush, pixel past the end, late flush
      set_geometry(1'b1, 2, 1'b1, 2);
      push_word(OP_PIXEL, {8'h00, 8'h00, 8'h00});
      push_word(OP_PIXEL, {8'hff, 8'hff, 8'hff});
      push_word(OP_FLUSH, random_pixel());
      push_word(OP_PIXEL, {8'hff, 8'h00, 8'hff});
      push_word(OP_PIXEL, {8'h00, 8'hff, 8'h00});
      push_word(OP_FLUSH, random_pixel());
      push_word(OP_PIXEL, {8'h5a, 8'ha5, 8'h3c});
      push_word(OP_FLUSH, random_pixel());
      push_word(OP_FLUSH, random_pixel());

      // zero geometry behaves as a single pixel
      set_geometry(1'b1, 0, 1'b1, 0);
      push_word(OP_PIXEL, {8'h80, 8'h40, 8'h01});

      // geometry written mid-frame only applies to the next frame
      set_geometry(1'b1, 3, 1'b1, 2);
      push_word(OP_PIXEL, random_pixel());
      set_geometry(1'b1, 1, 1'b1, 1);
      repeat (5) push_word(OP_PIXEL, random_pixel());
      repeat (4) push_word(OP_FLUSH, random_pixel());
      push_word(OP_PIXEL, random_pixel());

      // random frames under three idling mixes
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct   = (phase == 0) ? 22 : (phase == 1) ? 55 : 0;
         recv_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 22 : 0;
         phase_start = words_sent;
         while (words_sent < phase_start + WORDS_PER_PHASE)
            random_frame();
      end

      // zero width, height clamped from above: a single column of full height
      set_geometry(1'b1, 0, 1'b1, 2047);
      send_frame(1, MAX_HEIGHT);

      settle();
      if (fail_count == 0 && pending_results == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
